FILE: rtl/qpme_pkg.sv
// Shared types, character codes and helpers for the quoted-printable mail encoder.
// No dependencies; every other file in rtl/ imports this package.
package qpme_pkg;

    // Longest request one input byte may produce
    localparam int unsigned RUN_MAX = 6;
    localparam int unsigned RUN_CNT_W = $clog2(RUN_MAX + 1);
    localparam int unsigned RUN_BITS = 8 * RUN_MAX;

    // Encoding modes held in the configuration register
    localparam logic MODE_BODY   = 1'b0;
    localparam logic MODE_HEADER = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] PRINT_LO   = 8'd33;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam logic [7:0] HDR_HI     = 8'd127;

    // Line state carried from one input byte to the next
    typedef struct packed {
        logic space_pending;
        logic at_line_start;
    } qpme_state_t;

    // Encoded request for one input byte, slot 0 in the low byte
    typedef struct packed {
        logic [RUN_BITS-1:0]  bytes;
        logic [RUN_CNT_W-1:0] count;
    } qpme_run_t;

    // Upper-case hex digit for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'h0, nib};
        end
        else
        begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

    // "=HH" escape, first character in the low byte
    function automatic logic [23:0] hex_escape(input logic [7:0] b);
        return {hex_digit(b[3:0]), hex_digit(b[7:4]), CHAR_EQ};
    endfunction

endpackage

FILE: rtl/qpme_encode.sv
// Single-pass combinational encoder: one input byte plus line state in,
// packed output request and next line state out. Depends on qpme_pkg.
module qpme_encode (
    input  logic [7:0]           data_byte,
    input  logic                 end_of_text,
    input  logic                 mode,
    input  qpme_pkg::qpme_state_t state_cur,
    output qpme_pkg::qpme_state_t state_next,
    output qpme_pkg::qpme_run_t   run
);
    import qpme_pkg::*;

    logic [23:0] piece_a;
    logic [23:0] piece_b;
    logic [15:0] piece_c;
    logic [1:0]  len_a;
    logic [1:0]  len_b;
    logic [1:0]  len_c;
    logic        als_mid;
    logic        als_post;
    logic        sp_post;
    logic        is_crlf;
    logic        printable;
    logic [3:0]  total;
    logic [63:0] seq;
    logic [5:0]  shift_b;
    logic [5:0]  shift_c;

    // Build the held-space prefix, the byte itself and, in body mode, the closing line break
    always_comb
    begin
        piece_a   = '0;
        piece_b   = '0;
        piece_c   = '0;
        len_a     = 2'd0;
        len_b     = 2'd0;
        len_c     = 2'd0;
        is_crlf   = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
        printable = (data_byte >= PRINT_LO) && (data_byte <= PRINT_HI)
                    && (data_byte != CHAR_EQ);
        als_mid   = state_cur.at_line_start;
        als_post  = state_cur.at_line_start;
        sp_post   = 1'b0;

        if (mode == MODE_BODY)
        begin
            // flush a held space: literal unless a line break follows
            if (state_cur.space_pending)
            begin
                if (is_crlf)
                begin
                    piece_a = hex_escape(CHAR_SPACE);
                    len_a   = 2'd3;
                end
                else
                begin
                    piece_a = {16'h0, CHAR_SPACE};
                    len_a   = 2'd1;
                end
                als_mid = 1'b0;
            end
            als_post = als_mid;

            if (data_byte == CHAR_SPACE)
            begin
                if (end_of_text)
                begin
                    piece_b  = hex_escape(CHAR_SPACE);
                    len_b    = 2'd3;
                    als_post = 1'b0;
                end
                else
                begin
                    sp_post = 1'b1;
                end
            end
            else if (printable)
            begin
                // double a dot at the start of a line
                if ((data_byte == CHAR_DOT) && als_mid)
                begin
                    piece_b = {8'h0, CHAR_DOT, CHAR_DOT};
                    len_b   = 2'd2;
                end
                else
                begin
                    piece_b = {16'h0, data_byte};
                    len_b   = 2'd1;
                end
                als_post = 1'b0;
            end
            else if (data_byte == CHAR_CR)
            begin
                // drop bare CR
            end
            else if (data_byte == CHAR_LF)
            begin
                piece_b  = {8'h0, CHAR_LF, CHAR_CR};
                len_b    = 2'd2;
                als_post = 1'b1;
            end
            else
            begin
                piece_b  = hex_escape(data_byte);
                len_b    = 2'd3;
                als_post = 1'b0;
            end

            // close an unfinished line at end of text
            if (end_of_text && !als_post)
            begin
                piece_c = {CHAR_LF, CHAR_CR};
                len_c   = 2'd2;
            end
        end
        else
        begin
            if (state_cur.space_pending)
            begin
                piece_a = hex_escape(CHAR_SPACE);
                len_a   = 2'd3;
            end
            if (data_byte == CHAR_NUL)
            begin
                // drop zero byte
            end
            else if ((data_byte < CHAR_SPACE) || (data_byte > HDR_HI)
                     || (data_byte == CHAR_EQ) || (data_byte == CHAR_QMARK)
                     || (data_byte == CHAR_SPACE))
            begin
                piece_b = hex_escape(data_byte);
                len_b   = 2'd3;
            end
            else
            begin
                piece_b = {16'h0, data_byte};
                len_b   = 2'd1;
            end
        end
    end

    // Pack the pieces back to back and cap the request length
    always_comb
    begin
        shift_b = {1'b0, len_a, 3'b000};
        shift_c = {3'(len_a) + 3'(len_b), 3'b000};
        seq     = 64'(piece_a) | (64'(piece_b) << shift_b) | (64'(piece_c) << shift_c);
        total   = 4'(len_a) + 4'(len_b) + 4'(len_c);
        run.bytes = seq[RUN_BITS-1:0];
        if (total > 4'(RUN_MAX))
        begin
            run.count = RUN_CNT_W'(RUN_MAX);
        end
        else
        begin
            run.count = total[RUN_CNT_W-1:0];
        end
    end

    // End of text starts a fresh line with nothing held
    always_comb
    begin
        state_next.space_pending = sp_post && !end_of_text;
        state_next.at_line_start = als_post || end_of_text;
    end

endmodule

FILE: rtl/qpme_run.sv
// Result register and serializer: holds one encoded request and sends it
// one byte per cycle on the output channel while out_stall is low. Depends on qpme_pkg.
module qpme_run (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  qpme_pkg::qpme_run_t run_in,
    output logic                run_free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                last_of_run
);
    import qpme_pkg::*;

    logic [RUN_BITS-1:0]  buf_reg;
    logic [RUN_BITS-1:0]  buf_next;
    logic [RUN_CNT_W-1:0] cnt_reg;
    logic [RUN_CNT_W-1:0] cnt_next;
    logic                 take;

    assign take        = out_valid && !out_stall;
    assign out_valid   = (cnt_reg != '0);
    assign out_byte    = buf_reg[7:0];
    assign last_of_run = (cnt_reg == RUN_CNT_W'(1));
    // Free when empty or the final byte leaves this cycle
    assign run_free    = (cnt_reg == '0) || (last_of_run && take);

    // Load a new request or advance past the byte just taken
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = run_in.bytes;
            cnt_next = run_in.count;
        end
        else if (take)
        begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    // Never overwrite bytes still owed downstream
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> run_free)
        else $error("request loaded over undelivered bytes");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RUN_CNT_W'(RUN_MAX))
        else $error("request count out of range");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_of_run) |=> (cnt_reg == $past(cnt_reg) - RUN_CNT_W'(1)))
        else $error("serializer skipped or repeated a byte");

endmodule

FILE: rtl/quoted_printable_mail_encoder.sv
// Top level of the quoted-printable mail encoder: input register, line state,
// mode register, encoder and serializer. Depends on qpme_pkg, qpme_encode, qpme_run.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    data_byte, end_of_text
//   output   out        out_valid / out_stall  out_byte, last_of_run
//   config   in         cfg_wr_en              cfg_wr_data (encode_mode)
//
// An input byte waits in the input register, is encoded in one pass
// and its request (0 to 6 bytes) lands in the result register, which sends
// one byte per cycle while out_stall is low. Sustained rate: one input byte per
// cycle while each yields at most one output byte and the output is not stalled.
// Reset: mode body, line start set, no space held; no clearing pass.
// Output stall holds the result register, which backs up the input.
module quoted_printable_mail_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);
    import qpme_pkg::*;

    logic        mode_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [7:0]  item_byte_reg;
    logic        item_last_reg;
    qpme_state_t state_reg;
    qpme_state_t state_enc;
    qpme_run_t   run_enc;
    logic        run_free;
    logic        advance;
    logic        accept;

    // Encode the held byte against the current line state
    qpme_encode u_encode (
        .data_byte   (item_byte_reg),
        .end_of_text (item_last_reg),
        .mode        (mode_reg),
        .state_cur   (state_reg),
        .state_next  (state_enc),
        .run         (run_enc)
    );

    qpme_run u_run (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && (run_enc.count != '0)),
        .run_in      (run_enc),
        .run_free    (run_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // Move the held byte on when its request has room, or produces nothing
    assign advance  = item_valid_reg && (run_free || (run_enc.count == '0));
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    // Hold control state: mode, input valid and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg                <= MODE_BODY;
            item_valid_reg          <= 1'b0;
            state_reg.space_pending <= 1'b0;
            state_reg.at_line_start <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            item_valid_reg <= item_valid_next;
            if (advance)
            begin
                state_reg <= state_enc;
            end
        end
    end

    // Capture the input request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_byte_reg <= data_byte;
            item_last_reg <= end_of_text;
        end
    end

    a_text_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_last_reg) |=> (state_reg.at_line_start && !state_reg.space_pending))
        else $error("line state not reset after end of text");

endmodule
